FILE: rtl/successor_table_engine_macros.svh
// assertion helpers for the successor table engine
`ifndef SUCCESSOR_TABLE_ENGINE_MACROS_SVH
`define SUCCESSOR_TABLE_ENGINE_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define STE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("successor table engine check failed");
// next-cycle implication
`define STE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("successor table engine check failed");
`else
`define STE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define STE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/ste_pkg.sv
`default_nettype none

package ste_pkg;

  localparam int SEQ_W = 3;
  localparam int SYM_W = 2;
  localparam int POS_W = 11;
  localparam int CMD_W = 2;

  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // command queue between front and back, power of two
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_APPEND,
    OP_QUERY,
    OP_CLEAR
  } op_kind_t;

  typedef struct packed {
    op_kind_t           kind;
    logic [SEQ_W-1:0]   seq;
    logic [SYM_W-1:0]   sym;
    logic [POS_W-1:0]   key;
    logic               last;
    logic               bad;   // sequence or symbol out of range
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_QRES
  } st_t;

endpackage

`default_nettype wire

FILE: rtl/ste_ram.sv
`default_nettype none

module ste_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/ste_front.sv
`default_nettype none

module ste_front #(
  parameter int NUM_SEQUENCES = 8,
  parameter int ALPHABET_SIZE = 4
) (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ste_pkg::CMD_W-1:0]   in_cmd,
  input  logic [ste_pkg::SEQ_W-1:0]   in_seq_index,
  input  logic [ste_pkg::SYM_W-1:0]   in_symbol,
  input  logic [ste_pkg::POS_W-1:0]   in_key,
  input  logic                        in_last,
  input  ste_pkg::q_stat_t            q_stat,
  output logic                        q_push,
  output ste_pkg::op_t                q_op
);
  import ste_pkg::*;

  logic in_range;
  logic keep;

  assign in_range = (int'(in_seq_index) < NUM_SEQUENCES) &&
                    (int'(in_symbol) < ALPHABET_SIZE);

  // decode; out-of-range appends and unused codes never reach the queue
  always_comb begin
    keep       = 1'b0;
    q_op.kind  = OP_QUERY;
    case (in_cmd)
      CMD_APPEND: begin
        keep      = in_range;
        q_op.kind = OP_APPEND;
      end
      CMD_QUERY: begin
        keep      = 1'b1;
        q_op.kind = OP_QUERY;
      end
      CMD_CLEAR: begin
        keep      = 1'b1;
        q_op.kind = OP_CLEAR;
      end
      default: begin
        keep      = 1'b0;
        q_op.kind = OP_QUERY;
      end
    endcase
    q_op.seq  = in_seq_index;
    q_op.sym  = in_symbol;
    q_op.key  = in_key;
    q_op.last = in_last;
    q_op.bad  = !in_range;
  end

  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && in_ready && keep;

endmodule

`default_nettype wire

FILE: rtl/ste_queue.sv
`default_nettype none

module ste_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ste_pkg::op_t     push_op,
  input  logic             pop,
  output ste_pkg::op_t     head_op,
  output ste_pkg::q_stat_t stat
);
  import ste_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  assign head_op    = slot_r[rd_ptr_r];
  assign stat.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

`default_nettype wire

FILE: rtl/ste_back.sv
`default_nettype none

module ste_back #(
  parameter int NUM_SEQUENCES = 8,
  parameter int MAX_LENGTH    = 1024,
  parameter int ALPHABET_SIZE = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ste_pkg::q_stat_t          q_stat,
  input  ste_pkg::op_t              q_op,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ste_pkg::POS_W-1:0] out_successor,
  output logic                      out_matched,
  output logic                      out_run_end,
  output logic                      out_all_matched
);
  import ste_pkg::*;

  localparam int SW    = (NUM_SEQUENCES > 1) ? $clog2(NUM_SEQUENCES) : 1;
  localparam int RW    = $clog2(ALPHABET_SIZE);
  localparam int NROWS = NUM_SEQUENCES * ALPHABET_SIZE;
  localparam int MIW   = $clog2(NROWS);
  localparam int CW    = $clog2(MAX_LENGTH);
  localparam int PW    = $clog2(MAX_LENGTH + 1);
  localparam int KW    = (PW > POS_W) ? PW : POS_W;
  localparam int AW    = SW + RW + CW;

  st_t             state_r;
  st_t             state_nxt;
  logic [PW-1:0]   mark_r [NROWS];
  logic [PW-1:0]   len_r  [NUM_SEQUENCES];
  logic            run_failed_r;
  logic [PW-1:0]   col_r;
  logic [PW-1:0]   pos_r;
  logic [SW-1:0]   s_r;
  logic [RW-1:0]   c_r;
  logic [MIW-1:0]  row_r;
  logic            hit_r;
  logic            last_r;

  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [POS_W-1:0] out_successor_r;
  logic             out_matched_r;
  logic             out_run_end_r;
  logic             out_all_matched_r;

  logic            q_valid;
  logic [SW-1:0]   hs;
  logic [RW-1:0]   hc;
  logic [MIW-1:0]  hrow;
  logic [PW-1:0]   hmark;
  logic [PW-1:0]   hlen;
  logic [KW-1:0]   hkey;
  logic            head_full;
  logic            head_hit;
  logic            out_free;
  logic            fill_done;
  logic            res_load;
  logic            res_ok;
  logic [PW-1:0]   pos_inc;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [PW-1:0]   ram_rdata;

  // head decode, out of range indexes folded to entry zero
  assign q_valid   = !q_stat.empty;
  assign hs        = q_op.bad ? '0 : SW'(q_op.seq);
  assign hc        = q_op.bad ? '0 : RW'(q_op.sym);
  assign hrow      = MIW'(int'(hs) * ALPHABET_SIZE + int'(hc));
  assign hmark     = mark_r[hrow];
  assign hlen      = len_r[hs];
  assign hkey      = KW'(q_op.key);
  assign head_full = (hlen >= PW'(MAX_LENGTH));
  assign head_hit  = !q_op.bad && (hkey < KW'(hmark));

  assign out_free  = !out_valid_r || out_ready;
  assign fill_done = (col_r == pos_r);
  assign pos_inc   = pos_r + 1'b1;
  assign res_ok    = !run_failed_r && hit_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_op.kind)
            OP_APPEND: state_nxt = head_full ? ST_IDLE : ST_FILL;
            OP_QUERY:  state_nxt = ST_QRES;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_FILL: begin
        if (fill_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_QRES: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    res_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        q_pop  = q_valid;
        ram_re = q_valid && (q_op.kind == OP_QUERY);
      end
      ST_FILL: begin
        ram_we = 1'b1;
      end
      ST_QRES: begin
        res_load = out_free;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  assign ram_raddr = {hs, hc, hkey[CW-1:0]};
  assign ram_waddr = {s_r, c_r, col_r[CW-1:0]};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      run_failed_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < NROWS; i++) begin
        mark_r[i] <= '0;
      end
      for (int i = 0; i < NUM_SEQUENCES; i++) begin
        len_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (q_pop && (q_op.kind == OP_CLEAR)) begin
        run_failed_r <= 1'b0;
        for (int i = 0; i < NROWS; i++) begin
          mark_r[i] <= '0;
        end
        for (int i = 0; i < NUM_SEQUENCES; i++) begin
          len_r[i] <= '0;
        end
      end
      if ((state_r == ST_FILL) && fill_done) begin
        mark_r[row_r] <= pos_inc;
        len_r[s_r]    <= pos_inc;
      end
      if (res_load) begin
        // the last word of a run rearms it
        run_failed_r <= last_r ? 1'b0 : !res_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && (q_op.kind == OP_APPEND)) begin
      s_r   <= hs;
      c_r   <= hc;
      row_r <= hrow;
      col_r <= hmark;
      pos_r <= hlen;
    end else if (state_r == ST_FILL) begin
      col_r <= col_r + 1'b1;
    end
    if (q_pop && (q_op.kind == OP_QUERY)) begin
      hit_r  <= head_hit;
      last_r <= q_op.last;
    end
    if (res_load) begin
      out_successor_r   <= res_ok ? POS_W'(ram_rdata) : '0;
      out_matched_r     <= res_ok;
      out_run_end_r     <= last_r;
      out_all_matched_r <= last_r && res_ok;
    end
  end

  ste_ram #(
    .WIDTH (PW),
    .DEPTH (2 ** AW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (pos_inc),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_successor   = out_successor_r;
  assign out_matched     = out_matched_r;
  assign out_run_end     = out_run_end_r;
  assign out_all_matched = out_all_matched_r;

endmodule

`default_nettype wire

FILE: rtl/successor_table_engine.sv
// successor table engine: one next-occurrence table per sequence, kept in a single
// ram of NUM_SEQUENCES x ALPHABET_SIZE x MAX_LENGTH entries, each row gated by a
// fill mark in flip-flops so no clearing pass is needed after reset or clear.
// input words are decoded by a front stage and pass through a two-entry queue to
// the execution stage, so the input side keeps taking words while a fill runs or
// a result waits at the output register. an append writes one column per cycle,
// from the row's fill mark up to the new position, through the single ram write
// port. a query reads the ram as it is popped, then loads the result into the
// output register once it is free; a clear resets all marks and lengths as it is
// popped. appends to a full sequence or with an out-of-range sequence or symbol
// are dropped, and the unused command code is ignored, all without a result.
`default_nettype none
`include "successor_table_engine_macros.svh"

module successor_table_engine #(
  parameter int NUM_SEQUENCES = 8,
  parameter int MAX_LENGTH    = 1024,
  parameter int ALPHABET_SIZE = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input words
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ste_pkg::CMD_W-1:0] in_cmd,
  input  logic [ste_pkg::SEQ_W-1:0] in_seq_index,
  input  logic [ste_pkg::SYM_W-1:0] in_symbol,
  input  logic [ste_pkg::POS_W-1:0] in_key,
  input  logic                      in_last,
  // result words, one per query
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ste_pkg::POS_W-1:0] out_successor,
  output logic                      out_matched,
  output logic                      out_run_end,
  output logic                      out_all_matched
);
  import ste_pkg::*;

  // front to queue
  logic    q_push;
  op_t     q_push_op;
  // queue to back
  logic    q_pop;
  op_t     q_head_op;
  q_stat_t q_stat;

  // decode and range checks
  ste_front #(
    .NUM_SEQUENCES (NUM_SEQUENCES),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_seq_index (in_seq_index),
    .in_symbol    (in_symbol),
    .in_key       (in_key),
    .in_last      (in_last),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_op         (q_push_op)
  );

  // decoupling queue
  ste_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_push_op),
    .pop     (q_pop),
    .head_op (q_head_op),
    .stat    (q_stat)
  );

  // fills, lookups, run tracking and the output register
  ste_back #(
    .NUM_SEQUENCES (NUM_SEQUENCES),
    .MAX_LENGTH    (MAX_LENGTH),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .q_op            (q_head_op),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_successor   (out_successor),
    .out_matched     (out_matched),
    .out_run_end     (out_run_end),
    .out_all_matched (out_all_matched)
  );

  // queue never overruns or underruns
  `STE_ASSERT_IMP(a_no_overflow, clk, rst_n, q_push, !q_stat.full)
  `STE_ASSERT_IMP(a_no_underflow, clk, rst_n, q_pop, !q_stat.empty)
  // a pushed word is visible to the back next cycle
  `STE_ASSERT_NXT(a_push_seen, clk, rst_n, q_push, !q_stat.empty)
  // a failed run reports no position, and a full match only on run end
  `STE_ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid && !out_matched, out_successor == '0)
  `STE_ASSERT_IMP(a_all_match, clk, rst_n, out_valid && out_all_matched,
                  out_run_end && out_matched)

endmodule

`default_nettype wire
